FILE: hw/rtl/lqrm_pkg.sv
// Shared types, constants and elaboration-time helpers for the log quartic ramp evaluator.
// Depends on nothing; imported by lqrm_log, lqrm_horn and log_quartic_ramp_model.
`default_nettype none
package lqrm_pkg;

	localparam int unsigned LW = 29;   // Q4.24 log term, signed
	localparam int unsigned AW = 47;   // Horner accumulator, signed Q30.16
	localparam logic [27:0] LN2_Q28 = 28'd186065279;

	localparam logic [2:0] REG_TIME_OFFSET   = 3'd0;
	localparam logic [2:0] REG_COEF_QUARTIC  = 3'd1;
	localparam logic [2:0] REG_COEF_CUBIC    = 3'd2;
	localparam logic [2:0] REG_COEF_SQUARE   = 3'd3;
	localparam logic [2:0] REG_COEF_LINEAR   = 3'd4;
	localparam logic [2:0] REG_COEF_CONSTANT = 3'd5;

	typedef struct packed {
		logic valid;
		logic below;
	} lqrm_ctl_t;

	// 30 fraction bits of log2(v / 2^31), v in [2^31, 2^32); elaboration only
	function automatic logic [29:0] lg_frac(input logic [31:0] v_in);
		logic [63:0] v;
		logic [29:0] res;
		v = {32'd0, v_in};
		res = '0;
		for (int k = 29; k >= 0; k--) begin
			v = (v * v) >> 31;
			if (v >= 64'h1_0000_0000) begin
				res[k] = 1'b1;
				v = v >> 1;
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/log_quartic_ramp_model.sv
// Log quartic ramp evaluator: y = a*L^4 + b*L^3 + c*L^2 + d*L + e, L = ln(x - x0).
// One request per cycle sustained while the output accepts; a stalled output holds the pipeline.
// Depth is set by the log unit: 32 restoring-divide stages and 30 squaring stages,
// then four Horner steps of four stages each and the saturating output register.
// Reset clears all valid bits and the six configuration registers to zero.
// Depends on lqrm_pkg, lqrm_log and lqrm_horn.
`default_nettype none
module log_quartic_ramp_model #(
	parameter int unsigned LOG_TABLE_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] model_value,
	output logic               before_offset,
	output logic               saturated,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import lqrm_pkg::*;

	logic signed [31:0] time_offset_q, coef_quartic_q, coef_cubic_q;
	logic signed [31:0] coef_square_q, coef_linear_q, coef_constant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_offset_q   <= '0;
			coef_quartic_q  <= '0;
			coef_cubic_q    <= '0;
			coef_square_q   <= '0;
			coef_linear_q   <= '0;
			coef_constant_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TIME_OFFSET:   time_offset_q   <= cfg_data;
				REG_COEF_QUARTIC:  coef_quartic_q  <= cfg_data;
				REG_COEF_CUBIC:    coef_cubic_q    <= cfg_data;
				REG_COEF_SQUARE:   coef_square_q   <= cfg_data;
				REG_COEF_LINEAR:   coef_linear_q   <= cfg_data;
				REG_COEF_CONSTANT: coef_constant_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lqrm_ctl_t hn_ctl [5];
	logic signed [AW-1:0] hn_acc [5];
	logic signed [LW-1:0] hn_ln  [5];
	logic en;

	logic               out_valid_q, below_q, sat_q;
	logic signed [31:0] value_q;

	// advance unless the last stage is stuck behind a full, stalled output
	assign en       = !hn_ctl[4].valid || !out_valid_q || out_ready;
	assign in_ready = en;

	// offset subtract
	logic [32:0] diff;
	assign diff = {sample_time[31], sample_time} - {time_offset_q[31], time_offset_q};

	lqrm_ctl_t   ctl_s1;
	logic [31:0] span_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.below <= diff[32] || (diff == 33'd0);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			span_s1 <= diff[31:0];
		end
	end

	lqrm_log #(
		.TABLE_BITS(LOG_TABLE_BITS)
	) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_s1),
		.span   (span_s1),
		.ctl_out(hn_ctl[0]),
		.ln_val (hn_ln[0])
	);

	assign hn_acc[0] = 47'(coef_quartic_q);

	logic signed [31:0] step_coef [4];
	assign step_coef[0] = coef_cubic_q;
	assign step_coef[1] = coef_square_q;
	assign step_coef[2] = coef_linear_q;
	assign step_coef[3] = coef_constant_q;

	for (genvar s = 0; s < 4; s++) begin : g_horn
		lqrm_horn u_horn (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (hn_ctl[s]),
			.acc_in (hn_acc[s]),
			.ln_in  (hn_ln[s]),
			.coef   (step_coef[s]),
			.ctl_out(hn_ctl[s+1]),
			.acc_out(hn_acc[s+1]),
			.ln_out (hn_ln[s+1])
		);
	end

	// saturate into the output register
	logic ovf;
	assign ovf = !((&hn_acc[4][AW-1:31]) || !(|hn_acc[4][AW-1:31]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= hn_ctl[4].valid;
		end
	end
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			below_q <= hn_ctl[4].below;
			sat_q   <= !hn_ctl[4].below && ovf;
			if (hn_ctl[4].below) begin
				value_q <= coef_constant_q;
			end else if (ovf) begin
				value_q <= hn_acc[4][AW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else begin
				value_q <= hn_acc[4][31:0];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign model_value   = value_q;
	assign before_offset = below_q;
	assign saturated     = sat_q;

	a_before_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && below_q |-> !sat_q)
		else $error("before_offset request flagged saturated");

	a_before_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && below_q && $stable(coef_constant_q) && $past(out_valid_q)
		&& $past(below_q) |-> value_q == coef_constant_q)
		else $error("before_offset result is not the constant term");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> value_q == 32'sh8000_0000 || value_q == 32'sh7fff_ffff)
		else $error("saturated result not at a limit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q && !out_ready && hn_ctl[4].valid)
		else $error("pipeline stalled without a blocked output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hn_ctl[4].valid && en |=> out_valid_q)
		else $error("last stage request lost");

endmodule
`default_nettype wire

FILE: hw/rtl/lqrm_log.sv
// Pipelined natural log of a Q16.16 distance, result in signed Q4.24.
// Normalize, table lookup, restoring divide, squaring log2, scale by ln 2.
// Depends on lqrm_pkg.
`default_nettype none
module lqrm_log #(
	parameter int unsigned TABLE_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  lqrm_pkg::lqrm_ctl_t       ctl_in,
	input  logic [31:0]               span,
	output lqrm_pkg::lqrm_ctl_t       ctl_out,
	output logic signed [lqrm_pkg::LW-1:0] ln_val
);
	import lqrm_pkg::*;

	localparam int unsigned TAB_N = 1 << TABLE_BITS;
	localparam int unsigned DIV_N = 32;
	localparam int unsigned LG_N  = 30;

	logic [29:0] log_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam logic [29:0] ENT = lg_frac(32'h8000_0000 | (32'(g) << (31 - TABLE_BITS)));
		assign log_tab[g] = ENT;
	end

	// normalize
	logic [4:0]  lead;
	logic [31:0] norm;
	always_comb begin
		lead = '0;
		for (int b = 0; b < 32; b++) begin
			if (span[b]) begin
				lead = 5'(b);
			end
		end
	end
	assign norm = span << (5'd31 - lead);

	lqrm_ctl_t   ctl_s1;
	logic [4:0]  lead_s1;
	logic [31:0] norm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lead_s1 <= lead;
			norm_s1 <= norm;
		end
	end

	// table lookup and divider setup
	logic [TABLE_BITS-1:0] idx;
	assign idx = norm_s1[30 -: TABLE_BITS];

	lqrm_ctl_t   dv_ctl_s [DIV_N+1];
	logic [31:0] dv_rem_s [DIV_N+1];
	logic [31:0] dv_q_s   [DIV_N+1];
	logic [31:0] dv_bs_s  [DIV_N+1];
	logic [4:0]  dv_p_s   [DIV_N+1];
	logic [29:0] dv_tab_s [DIV_N+1];
	logic        lsb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctl_s[0] <= '0;
		end else if (en) begin
			dv_ctl_s[0] <= ctl_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= {1'b0, norm_s1[31:1]};
			lsb_s2      <= norm_s1[0];
			dv_q_s[0]   <= '0;
			dv_bs_s[0]  <= {1'b1, idx, {(31 - TABLE_BITS){1'b0}}};
			dv_p_s[0]   <= lead_s1;
			dv_tab_s[0] <= log_tab[idx];
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic [32:0] trial;
		logic [33:0] diff;
		logic        ge;
		assign trial = {dv_rem_s[j], (j == 0) ? lsb_s2 : 1'b0};
		assign diff  = {1'b0, trial} - {2'b00, dv_bs_s[j]};
		assign ge    = !diff[33];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_ctl_s[j+1] <= '0;
			end else if (en) begin
				dv_ctl_s[j+1] <= dv_ctl_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= ge ? diff[31:0] : trial[31:0];
				dv_q_s[j+1]   <= {dv_q_s[j][30:0], ge};
				dv_bs_s[j+1]  <= dv_bs_s[j];
				dv_p_s[j+1]   <= dv_p_s[j];
				dv_tab_s[j+1] <= dv_tab_s[j];
			end
		end
	end

	// log2 of the residual, one squaring per stage
	lqrm_ctl_t   lg_ctl_s [LG_N];
	logic [31:0] lg_v_s   [LG_N];
	logic [29:0] lg_res_s [LG_N];
	logic [4:0]  lg_p_s   [LG_N];
	logic [29:0] lg_tab_s [LG_N];

	for (genvar j = 0; j < LG_N; j++) begin : g_lg
		lqrm_ctl_t   c_in;
		logic [31:0] v_in;
		logic [29:0] r_in;
		logic [4:0]  p_in;
		logic [29:0] t_in;
		logic [63:0] sq;
		logic [32:0] w;

		if (j == 0) begin : g_src
			assign c_in = dv_ctl_s[DIV_N];
			assign v_in = dv_q_s[DIV_N];
			assign r_in = '0;
			assign p_in = dv_p_s[DIV_N];
			assign t_in = dv_tab_s[DIV_N];
		end else begin : g_src
			assign c_in = lg_ctl_s[j-1];
			assign v_in = lg_v_s[j-1];
			assign r_in = lg_res_s[j-1];
			assign p_in = lg_p_s[j-1];
			assign t_in = lg_tab_s[j-1];
		end

		assign sq = 64'(v_in) * 64'(v_in);
		assign w  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_ctl_s[j] <= '0;
			end else if (en) begin
				lg_ctl_s[j] <= c_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lg_v_s[j]   <= w[32] ? w[32:1] : w[31:0];
				lg_res_s[j] <= {r_in[28:0], w[32]};
				lg_p_s[j]   <= p_in;
				lg_tab_s[j] <= t_in;
			end
		end
	end

	// assemble log2 in Q.30
	logic signed [5:0]  expo;
	logic        [35:0] l2_next;
	assign expo    = $signed({1'b0, lg_p_s[LG_N-1]}) - 6'sd16;
	assign l2_next = {expo, 30'd0} + 36'(lg_tab_s[LG_N-1]) + 36'(lg_res_s[LG_N-1]);

	lqrm_ctl_t          l2_ctl_s;
	logic signed [35:0] l2_s;
	lqrm_ctl_t          pr_ctl_s;
	logic signed [46:0] pr_hi_s;
	logic        [45:0] pr_lo_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_ctl_s <= '0;
			pr_ctl_s <= '0;
			ctl_out  <= '0;
		end else if (en) begin
			l2_ctl_s <= lg_ctl_s[LG_N-1];
			pr_ctl_s <= l2_ctl_s;
			ctl_out  <= pr_ctl_s;
		end
	end

	// scale by ln 2, split into two partial products
	logic signed [65:0] sum;
	assign sum = (66'(pr_hi_s) <<< 18) + $signed(66'(pr_lo_s)) + $signed(66'd1 << 33);

	always_ff @(posedge clk) begin
		if (en) begin
			l2_s    <= $signed(l2_next);
			pr_hi_s <= 47'($signed(l2_s[35:18]) * $signed({1'b0, LN2_Q28}));
			pr_lo_s <= 46'(l2_s[17:0] * LN2_Q28);
			ln_val  <= sum[62:34];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lqrm_horn.sv
// One Horner step: acc * L rounded back to Q16.16, plus a coefficient; four stages.
// Depends on lqrm_pkg.
`default_nettype none
module lqrm_horn (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  lqrm_pkg::lqrm_ctl_t            ctl_in,
	input  logic signed [lqrm_pkg::AW-1:0] acc_in,
	input  logic signed [lqrm_pkg::LW-1:0] ln_in,
	input  logic signed [31:0]             coef,
	output lqrm_pkg::lqrm_ctl_t            ctl_out,
	output logic signed [lqrm_pkg::AW-1:0] acc_out,
	output logic signed [lqrm_pkg::LW-1:0] ln_out
);
	import lqrm_pkg::*;

	lqrm_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic signed [LW-1:0] ln_s1, ln_s2, ln_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [45:0] ua_s1;
	logic [27:0] ul_s1;
	logic [49:0] ph_s2;
	logic [51:0] pl_s2;
	logic [AW-1:0] mag_s3;
	logic [52:0] pl_rnd;

	assign pl_rnd = 53'(pl_s2) + 53'd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_out <= '0;
		end else if (en) begin
			ctl_s1  <= ctl_in;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_out <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= acc_in[AW-1] ^ ln_in[LW-1];
			ua_s1   <= acc_in[AW-1] ? 46'(-acc_in) : acc_in[45:0];
			ul_s1   <= ln_in[LW-1] ? 28'(-ln_in) : ln_in[27:0];
			ln_s1   <= ln_in;

			neg_s2  <= neg_s1;
			ph_s2   <= 50'(ua_s1[45:24] * ul_s1);
			pl_s2   <= 52'(ua_s1[23:0] * ul_s1);
			ln_s2   <= ln_s1;

			neg_s3  <= neg_s2;
			mag_s3  <= 47'(ph_s2 + 50'(pl_rnd >> 24));
			ln_s3   <= ln_s2;

			acc_out <= neg_s3 ? (47'(coef) - $signed(mag_s3)) : (47'(coef) + $signed(mag_s3));
			ln_out  <= ln_s3;
		end
	end

endmodule
`default_nettype wire
